FILE: hdl/c2d_pkg.sv
`default_nettype none

package c2d_pkg;

   localparam int MAX_WIDTH      = 1024;
   localparam int KERNEL_SIZE    = 3;
   localparam int COEF_FRAC_BITS = 8;
   localparam int MAX_HEIGHT     = 4096;
   localparam int PIX_MAX        = 255;

   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int WCNT_W    = COL_W + 1;
   localparam int PIX_W     = 8;
   localparam int CFG_W_W   = 11;
   localparam int CFG_H_W   = 13;
   localparam int COEF_W    = 48;
   localparam int TAP_W     = 16;
   localparam int IN_ROW_W  = 13;
   localparam int OUT_ROW_W = 12;
   localparam int CSR_IDX_W = 3;
   localparam int LINE_W    = 2 * PIX_W;
   localparam int PROD_W    = TAP_W + PIX_W + 1;
   localparam int CSUM_W    = PROD_W + 2;
   localparam int SUM_W     = CSUM_W + 2;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_TOP = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_MID = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_BOT = 3'd4;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   localparam logic [CFG_W_W-1:0] WIDTH_RESET    = 11'd1024;
   localparam logic [CFG_H_W-1:0] HEIGHT_RESET   = 13'd768;
   localparam logic [COEF_W-1:0]  COEF_TOP_RESET = 48'h0000_0000_0000;
   localparam logic [COEF_W-1:0]  COEF_MID_RESET = 48'h0000_0100_0000;
   localparam logic [COEF_W-1:0]  COEF_BOT_RESET = 48'h0000_0000_0000;

   typedef struct packed {
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      logic [PIX_W-1:0] bot;
   } column_type;

   typedef struct packed {
      logic                   shift;
      logic                   advance;
      logic [KERNEL_SIZE-1:0] row_en;
      logic                   col_en;
   } cell_ctrl_type;

endpackage

`default_nettype wire

FILE: hdl/c2d_req_if.sv
`default_nettype none

interface c2d_req_if import c2d_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             opcode;
   logic [PIX_W-1:0] pixel_in;

   modport source (output valid, output opcode, output pixel_in, input ready);
   modport sink (input valid, input opcode, input pixel_in, output ready);
endinterface

`default_nettype wire

FILE: hdl/c2d_rsp_if.sv
`default_nettype none

interface c2d_rsp_if import c2d_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_out;
   logic             frame_last;

   modport source (output valid, output pixel_out, output frame_last, input ready);
   modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface

`default_nettype wire

FILE: hdl/c2d_ram.sv
`default_nettype none

module c2d_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/c2d_cell.sv
`default_nettype none

module c2d_cell import c2d_pkg::*; (
   input  logic                                clock,
   input  logic                                reset,
   input  cell_ctrl_type                       ctrl,
   input  column_type                          col_in,
   input  logic [KERNEL_SIZE-1:0][TAP_W-1:0]   taps,
   output column_type                          col_out,
   output logic signed [CSUM_W-1:0]            col_sum
);

   column_type              pix_ff;
   column_type              pix_in;
   logic [PIX_W-1:0]        pix_row [KERNEL_SIZE];
   logic signed [PROD_W-1:0] prod_ff [KERNEL_SIZE];
   logic signed [PROD_W-1:0] prod_in [KERNEL_SIZE];
   logic signed [CSUM_W-1:0] sum_ff;
   logic signed [CSUM_W-1:0] sum_in;

   always_comb begin
      pix_in = ctrl.shift ? col_in : pix_ff;
      pix_row[0] = pix_ff.top;
      pix_row[1] = pix_ff.mid;
      pix_row[2] = pix_ff.bot;
      for (int r = 0; r < KERNEL_SIZE; r++) begin
         if (ctrl.row_en[r] && ctrl.col_en) begin
            prod_in[r] = PROD_W'($signed(taps[r])) * PROD_W'($signed({1'b0, pix_row[r]}));
         end else begin
            prod_in[r] = '0;
         end
      end
      sum_in = '0;
      for (int r = 0; r < KERNEL_SIZE; r++) begin
         sum_in = sum_in + CSUM_W'(prod_ff[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_ff <= '0;
      end else begin
         pix_ff <= pix_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
      end
   end

   assign col_out = pix_ff;
   assign col_sum = sum_ff;

endmodule

`default_nettype wire

FILE: hdl/conv2d_3x3_zero_pad.sv
// 3x3 correlation over a grayscale frame with zero padding at the borders.
// Pixels enter in raster order on req_bus, one beat per pixel; a beat with
// opcode set is a flush beat and counts as a zero pixel. After the last
// pixel of a frame, image_width + 1 flush beats push out the final results.
// Results leave on rsp_bus; frame_last marks the final pixel of a frame.
// The taps, width and height are to be written through the csr port only
// while the block is idle; the block itself does not enforce this. Each
// tap is signed with eight fraction bits. Throughput is one beat per clock
// in both directions while the receiver is ready. A result's window is
// completed by the beat image_width + 1 places after its own pixel; the
// path from that beat runs through a line store read, three window cells,
// a product stage, a column sum stage, a total stage and the output register.
// When the receiver stalls the whole pipeline holds and req_bus.ready falls
// in the same cycle; nothing is lost.
// After reset the line store is cleared, one column per cycle, with
// req_bus.ready low until all MAX_WIDTH (1024) columns are clear; csr writes
// are taken as ever. Reset restores width 1024, height 768 and the identity kernel.
`default_nettype none

module conv2d_3x3_zero_pad import c2d_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   c2d_req_if.sink              req_bus,
   c2d_rsp_if.source            rsp_bus,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]    csr_wdata
);

   logic [CFG_W_W-1:0] width_ff;
   logic [CFG_H_W-1:0] height_ff;
   logic [COEF_W-1:0]  coef_ff [KERNEL_SIZE];
   logic [WCNT_W-1:0]  eff_w;
   logic [CFG_H_W-1:0] eff_h;

   logic [COL_W-1:0]     in_col_ff, in_col_in;
   logic [IN_ROW_W-1:0]  in_row_ff, in_row_in;
   logic [COL_W-1:0]     out_col_ff, out_col_in;
   logic [OUT_ROW_W-1:0] out_row_ff, out_row_in;

   logic clr_busy_ff;
   logic [COL_W-1:0] clr_addr_ff;

   logic adv_c, accept_c, in_wrap_c, res_c, last_c;
   logic top_en_c, bot_en_c, left_en_c, right_en_c;

   logic                   a_valid_ff, a_res_ff, a_last_ff;
   logic [KERNEL_SIZE-1:0] a_row_en_ff, a_col_en_ff;
   logic [PIX_W-1:0]       a_pix_ff;
   logic [COL_W-1:0]       a_col_ff;
   logic                   b_res_ff, b_last_ff;
   logic [KERNEL_SIZE-1:0] b_row_en_ff, b_col_en_ff;
   logic                   c_res_ff, c_last_ff;
   logic                   d_res_ff, d_last_ff;
   logic                   e_res_ff, e_last_ff;
   logic signed [SUM_W-1:0] total_ff, total_in, rnd_c;
   logic                   out_valid_ff, out_last_ff;
   logic [PIX_W-1:0]       out_pix_ff, clamp_c;

   logic              ram_wr_en;
   logic [COL_W-1:0]  ram_wr_addr;
   logic [LINE_W-1:0] ram_wr_data, ram_rd_data, line_c;
   logic              byp_ff;
   logic [LINE_W-1:0] byp_data_ff;
   column_type        new_col_c;
   column_type        col_link [KERNEL_SIZE];
   logic signed [CSUM_W-1:0] col_sum [KERNEL_SIZE];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WIDTH_RESET;
         height_ff  <= HEIGHT_RESET;
         coef_ff[0] <= COEF_TOP_RESET;
         coef_ff[1] <= COEF_MID_RESET;
         coef_ff[2] <= COEF_BOT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_WIDTH:    width_ff   <= csr_wdata[CFG_W_W-1:0];
            CSR_HEIGHT:   height_ff  <= csr_wdata[CFG_H_W-1:0];
            CSR_COEF_TOP: coef_ff[0] <= csr_wdata;
            CSR_COEF_MID: coef_ff[1] <= csr_wdata;
            CSR_COEF_BOT: coef_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         eff_w = WCNT_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         eff_w = WCNT_W'(MAX_WIDTH);
      end else begin
         eff_w = WCNT_W'(width_ff);
      end
      if (height_ff == '0) begin
         eff_h = CFG_H_W'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         eff_h = CFG_H_W'(MAX_HEIGHT);
      end else begin
         eff_h = height_ff;
      end
   end

   assign adv_c         = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = adv_c && !clr_busy_ff;
   assign accept_c      = req_bus.valid && req_bus.ready;

   always_comb begin
      in_wrap_c  = (WCNT_W'(in_col_ff) + WCNT_W'(1)) >= eff_w;
      res_c      = (in_row_ff >= IN_ROW_W'(2)) ||
                   ((in_row_ff == IN_ROW_W'(1)) && (in_col_ff != '0));
      top_en_c   = out_row_ff != '0;
      bot_en_c   = (CFG_H_W'(out_row_ff) + CFG_H_W'(1)) < eff_h;
      left_en_c  = out_col_ff != '0;
      right_en_c = (WCNT_W'(out_col_ff) + WCNT_W'(1)) < eff_w;
      last_c     = !bot_en_c && !right_en_c;

      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (accept_c) begin
         if (in_wrap_c) begin
            in_col_in = '0;
            in_row_in = in_row_ff + IN_ROW_W'(1);
         end else begin
            in_col_in = in_col_ff + COL_W'(1);
         end
         if (res_c) begin
            if (last_c) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (!right_en_c) begin
               out_col_in = '0;
               out_row_in = out_row_ff + OUT_ROW_W'(1);
            end else begin
               out_col_in = out_col_ff + COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + COL_W'(1);
         if (clr_addr_ff == COL_W'(MAX_WIDTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // Each line store entry holds the row two above in its upper half and
   // the row above in its lower half.
   assign line_c    = byp_ff ? byp_data_ff : ram_rd_data;
   assign new_col_c = '{top: line_c[LINE_W-1:PIX_W], mid: line_c[PIX_W-1:0], bot: a_pix_ff};

   always_comb begin
      if (clr_busy_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_addr_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = adv_c && a_valid_ff;
         ram_wr_addr = a_col_ff;
         ram_wr_data = {line_c[PIX_W-1:0], a_pix_ff};
      end
   end

   c2d_ram #(
      .DATA_W (LINE_W),
      .DEPTH  (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept_c),
      .rd_addr (in_col_ff),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else if (accept_c) begin
         byp_ff <= adv_c && a_valid_ff && (a_col_ff == in_col_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (accept_c) begin
         byp_data_ff <= ram_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         a_res_ff     <= 1'b0;
         b_res_ff     <= 1'b0;
         c_res_ff     <= 1'b0;
         d_res_ff     <= 1'b0;
         e_res_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv_c) begin
         a_valid_ff   <= accept_c;
         a_res_ff     <= accept_c && res_c;
         b_res_ff     <= a_res_ff;
         c_res_ff     <= b_res_ff;
         d_res_ff     <= c_res_ff;
         e_res_ff     <= d_res_ff;
         out_valid_ff <= e_res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_c) begin
         a_pix_ff    <= (req_bus.opcode == OP_FLUSH) ? '0 : req_bus.pixel_in;
         a_col_ff    <= in_col_ff;
         a_last_ff   <= last_c;
         a_row_en_ff <= {bot_en_c, 1'b1, top_en_c};
         a_col_en_ff <= {right_en_c, 1'b1, left_en_c};
         b_last_ff   <= a_last_ff;
         b_row_en_ff <= a_row_en_ff;
         b_col_en_ff <= a_col_en_ff;
         c_last_ff   <= b_last_ff;
         d_last_ff   <= c_last_ff;
         e_last_ff   <= d_last_ff;
         total_ff    <= total_in;
         out_pix_ff  <= clamp_c;
         out_last_ff <= e_last_ff;
      end
   end

   for (genvar c = 0; c < KERNEL_SIZE; c++) begin : g_cell
      column_type                        cin;
      cell_ctrl_type                     ctrl;
      logic [KERNEL_SIZE-1:0][TAP_W-1:0] taps;

      if (c == KERNEL_SIZE - 1) begin : g_head
         assign cin = new_col_c;
      end else begin : g_body
         assign cin = col_link[c+1];
      end

      always_comb begin
         ctrl.shift   = adv_c && a_valid_ff;
         ctrl.advance = adv_c;
         ctrl.row_en  = b_row_en_ff;
         ctrl.col_en  = b_col_en_ff[c];
         for (int r = 0; r < KERNEL_SIZE; r++) begin
            taps[r] = coef_ff[r][c*TAP_W +: TAP_W];
         end
      end

      c2d_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (ctrl),
         .col_in  (cin),
         .taps    (taps),
         .col_out (col_link[c]),
         .col_sum (col_sum[c])
      );
   end

   always_comb begin
      total_in = '0;
      for (int c = 0; c < KERNEL_SIZE; c++) begin
         total_in = total_in + SUM_W'(col_sum[c]);
      end
      rnd_c = total_ff + SUM_W'(1 << (COEF_FRAC_BITS - 1));
      if (total_ff < 0) begin
         clamp_c = '0;
      end else if (rnd_c[SUM_W-1:COEF_FRAC_BITS] > (SUM_W - COEF_FRAC_BITS)'(PIX_MAX)) begin
         clamp_c = PIX_W'(PIX_MAX);
      end else begin
         clamp_c = rnd_c[PIX_W+COEF_FRAC_BITS-1:COEF_FRAC_BITS];
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.pixel_out  = out_pix_ff;
   assign rsp_bus.frame_last = out_last_ff;

   a_frame_end_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept_c && res_c && last_c) |=>
         (in_col_ff == '0 && in_row_ff == '0 && out_col_ff == '0 && out_row_ff == '0))
      else $error("Counters did not return to the frame start after the last result.");

   a_clear_covers_store: assert property (@(posedge clock) disable iff (reset)
      $fell(clr_busy_ff) |-> ($past(clr_addr_ff) == COL_W'(MAX_WIDTH - 1)))
      else $error("Line store clearing ended before the last column.");

   a_no_beat_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !(req_bus.valid && req_bus.ready))
      else $error("A pixel beat was taken while the line store was being cleared.");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import c2d_pkg::*;

   localparam int IDLE_GUARD       = 10;
   localparam int TAIL_CYCLES      = 20;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT   = 5000;
   localparam int HOLD_PHASE       = 4;
   localparam int HOLD_AT_BEAT     = 20;
   localparam int ITEM_TARGET      = 500;

   typedef struct packed {
      logic [PIX_W-1:0] pix;
      logic             last;
   } filt_result_type;

   typedef struct packed {
      logic             op;
      logic [PIX_W-1:0] pix;
      bit               has_want;
      filt_result_type  want;
   } stim_row_type;

   logic clock;
   logic reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COEF_W-1:0]    csr_wdata;

   c2d_req_if req_bus ();
   c2d_rsp_if rsp_bus ();

   conv2d_3x3_zero_pad dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Shadow copy of the filter: line stores, window, position counters and registers.
   logic [PIX_W-1:0]   upper_line [MAX_WIDTH];
   logic [PIX_W-1:0]   lower_line [MAX_WIDTH];
   logic [PIX_W-1:0]   win [9];
   int unsigned        in_col, in_row, out_col, out_row;
   logic [CFG_W_W-1:0] width_reg;
   logic [CFG_H_W-1:0] height_reg;
   logic [COEF_W-1:0]  coef_reg [3];

   filt_result_type pending_pixels [$];
   int           mismatch_count = 0;
   int unsigned  quiet_cycles = 0;
   bit           long_hold = 0;
   bit           send_burst = 0;

   // Two frames of 2x2 with the identity kernel left from reset: the
   // first reaches both pixel extremes, the second has a flush beat inside
   // the frame and real pixels among the drain beats.
   stim_row_type directed_rows [14] = '{
      '{OP_PIXEL, 8'd0,   1'b0, '{8'd0,   1'b0}},
      '{OP_PIXEL, 8'd255, 1'b0, '{8'd0,   1'b0}},
      '{OP_PIXEL, 8'd128, 1'b0, '{8'd0,   1'b0}},
      '{OP_PIXEL, 8'd1,   1'b1, '{8'd0,   1'b0}},
      '{OP_FLUSH, 8'd0,   1'b1, '{8'd255, 1'b0}},
      '{OP_FLUSH, 8'd170, 1'b1, '{8'd128, 1'b0}},
      '{OP_FLUSH, 8'd0,   1'b1, '{8'd1,   1'b1}},
      '{OP_PIXEL, 8'd7,   1'b0, '{8'd0,   1'b0}},
      '{OP_FLUSH, 8'd200, 1'b0, '{8'd0,   1'b0}},
      '{OP_PIXEL, 8'd9,   1'b0, '{8'd0,   1'b0}},
      '{OP_PIXEL, 8'd10,  1'b1, '{8'd7,   1'b0}},
      '{OP_PIXEL, 8'd99,  1'b1, '{8'd0,   1'b0}},
      '{OP_FLUSH, 8'd0,   1'b1, '{8'd9,   1'b0}},
      '{OP_PIXEL, 8'd255, 1'b1, '{8'd10,  1'b1}}
   };

   function automatic int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
   endfunction

   function automatic int unsigned eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
   endfunction

   task automatic filter_pixel(input logic op, input logic [PIX_W-1:0] pix_in,
                               output bit produced, output filt_result_type res);
      logic [PIX_W-1:0]   pix, top, mid;
      logic signed [15:0] t;
      int unsigned        w, h;
      int                 r, c;
      longint             acc, rounded;
      bit                 ready, last;
      w = eff_width();
      h = eff_height();
      pix = (op == OP_FLUSH) ? '0 : pix_in;
      top = '0;
      mid = '0;
      if (in_col < MAX_WIDTH) begin
         top = upper_line[in_col];
         mid = lower_line[in_col];
         upper_line[in_col] = mid;
         lower_line[in_col] = pix;
      end
      for (r = 0; r < 3; r++) begin
         win[r*3]   = win[r*3+1];
         win[r*3+1] = win[r*3+2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = pix;
      ready = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      if (in_col + 1 >= w) begin
         in_col = 0;
         in_row = (in_row + 1) & 32'h1FFF;
      end else begin
         in_col++;
      end
      produced = ready;
      res = '0;
      if (ready) begin
         acc = 0;
         for (r = 0; r < 3; r++) begin
            if (r == 0 && out_row == 0) continue;
            if (r == 2 && out_row + 1 >= h) continue;
            for (c = 0; c < 3; c++) begin
               if (c == 0 && out_col == 0) continue;
               if (c == 2 && out_col + 1 >= w) continue;
               t = coef_reg[r][16*c +: 16];
               acc += longint'(t) * longint'({1'b0, win[r*3+c]});
            end
         end
         if (acc < 0) begin
            res.pix = '0;
         end else begin
            rounded = (acc + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
            res.pix = (rounded > PIX_MAX) ? PIX_W'(PIX_MAX) : rounded[PIX_W-1:0];
         end
         last = (out_row + 1 >= h) && (out_col + 1 >= w);
         res.last = last;
         if (last) begin
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
         end else if (out_col + 1 >= w) begin
            out_col = 0;
            out_row = (out_row + 1) & 32'hFFF;
         end else begin
            out_col++;
         end
      end
   endtask

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      $display("MISMATCH at %0t ns: %s", $time, msg);
   endtask

   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [PIX_W-1:0] pick_pixel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return 8'd255;
         default: return PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [15:0] pick_tap();
      int v;
      case ($urandom_range(0, 11))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0080;
         3: return 16'hFF80;
         4: return 16'h0100;
         5: return 16'hFF00;
         6: return 16'h0000;
         7: return 16'($urandom_range(0, 65535));
         default: begin
            v = int'($urandom_range(0, 192)) - 64;
            return v[15:0];
         end
      endcase
   endfunction

   function automatic logic [COEF_W-1:0] coef_word();
      if ($urandom_range(0, 5) == 0) return {16'($urandom), $urandom};
      return {pick_tap(), pick_tap(), pick_tap()};
   endfunction

   // Called at a falling edge; raises the write enable for a rising edge and returns with it still high.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_WIDTH:    width_reg = data[CFG_W_W-1:0];
         CSR_HEIGHT:   height_reg = data[CFG_H_W-1:0];
         CSR_COEF_TOP: coef_reg[0] = data;
         CSR_COEF_MID: coef_reg[1] = data;
         CSR_COEF_BOT: coef_reg[2] = data;
         default: ;
      endcase
      @(negedge clock);
   endtask

   function automatic logic [COEF_W-1:0] dim_word(input int unsigned value, input int bits);
      logic [COEF_W-1:0] data;
      data = {16'($urandom), $urandom};
      if ($urandom_range(0, 3) != 0) data = '0;
      data = (data >> bits) << bits;
      return data | (COEF_W'(value) & ((COEF_W'(1) << bits) - 1));
   endfunction

   task automatic send_beat(input logic op, input logic [PIX_W-1:0] pix,
                            input bit has_want, input filt_result_type want);
      int              gap;
      bit              produced;
      filt_result_type got;
      gap = 0;
      if (!send_burst && $urandom_range(0, 99) < 30) gap = idle_span();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.opcode   <= op;
      req_bus.pixel_in <= pix;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      filter_pixel(op, pix, produced, got);
      if (has_want) pending_pixels.push_back(want);
      else if (produced) pending_pixels.push_back(got);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (IDLE_GUARD) @(negedge clock);
   endtask

   always @(posedge clock) begin
      filt_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_pixels.size() == 0) begin
            flag_mismatch($sformatf("result %0d/%0d with nothing pending",
                                    rsp_bus.pixel_out, rsp_bus.frame_last));
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_bus.pixel_out !== want.pix)
               flag_mismatch($sformatf("pixel_out got %0d want %0d",
                                       rsp_bus.pixel_out, want.pix));
            if (rsp_bus.frame_last !== want.last)
               flag_mismatch($sformatf("frame_last got %0b want %0b",
                                       rsp_bus.frame_last, want.last));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("conv2d_3x3_zero_pad regression: fail");
         $finish;
      end
   end

   // The receiver stalls on its own, and once holds off long enough for the block to fill.
   initial begin
      int stall_left, stall_pct, span;
      rsp_bus.ready = 1'b0;
      stall_left = 0;
      stall_pct = 20;
      span = 0;
      forever begin
         @(negedge clock);
         span++;
         if (span == 150) begin
            span = 0;
            case ($urandom_range(0, 3))
               0: stall_pct = 0;
               1: stall_pct = 5;
               2: stall_pct = 20;
               default: stall_pct = 50;
            endcase
         end
         if (long_hold) begin
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            long_hold = 0;
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if ($urandom_range(0, 99) < stall_pct) stall_left = idle_span();
         end
      end
   end

   initial begin
      int          phase, k, sent;
      int unsigned wv, hv, w, h, n_pix, total;
      bit          hold_here;
      logic        op;
      logic [CSR_IDX_W-1:0] spare;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.opcode = OP_PIXEL;
      req_bus.pixel_in = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_WIDTH;
      csr_wdata = '0;
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      coef_reg[0] = COEF_TOP_RESET;
      coef_reg[1] = COEF_MID_RESET;
      coef_reg[2] = COEF_BOT_RESET;
      for (k = 0; k < MAX_WIDTH; k++) begin
         upper_line[k] = '0;
         lower_line[k] = '0;
      end
      for (k = 0; k < 9; k++) win[k] = '0;
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      sent = 0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_reg(CSR_WIDTH, COEF_W'(2));
      write_reg(CSR_HEIGHT, COEF_W'(2));
      csr_wr_en <= 1'b0;
      foreach (directed_rows[i]) begin
         send_beat(directed_rows[i].op, directed_rows[i].pix,
                   directed_rows[i].has_want, directed_rows[i].want);
         sent++;
      end

      for (phase = 0; sent < ITEM_TARGET; phase++) begin
         hold_here = (phase == HOLD_PHASE);
         case (phase)
            2: begin
               wv = 0;
               hv = 0;
            end
            HOLD_PHASE: begin
               wv = 8;
               hv = 4;
            end
            default: begin
               if ($urandom_range(0, 5) == 0) begin
                  wv = $urandom_range(9, 40);
                  hv = $urandom_range(1, 3);
               end else begin
                  wv = $urandom_range(1, 8);
                  hv = $urandom_range(1, 6);
               end
            end
         endcase
         wait_idle();
         if ($urandom_range(0, 3) == 0) begin
            spare = CSR_COEF_BOT + CSR_IDX_W'($urandom_range(1, 3));
            write_reg(spare, {16'($urandom), $urandom});
         end
         write_reg(CSR_WIDTH, dim_word(wv, CFG_W_W));
         write_reg(CSR_HEIGHT, dim_word(hv, CFG_H_W));
         write_reg(CSR_COEF_TOP, coef_word());
         write_reg(CSR_COEF_MID, coef_word());
         write_reg(CSR_COEF_BOT, coef_word());
         csr_wr_en <= 1'b0;
         send_burst = hold_here || ($urandom_range(0, 3) == 0);
         w = eff_width();
         h = eff_height();
         n_pix = w * h;
         total = n_pix + w + 1;
         for (k = 0; k < total; k++) begin
            if (hold_here && k == HOLD_AT_BEAT) long_hold = 1'b1;
            if (k < n_pix) op = ($urandom_range(0, 19) == 0) ? OP_FLUSH : OP_PIXEL;
            else op = ($urandom_range(0, 1) == 0) ? OP_FLUSH : OP_PIXEL;
            send_beat(op, pick_pixel(), 1'b0, '0);
            sent++;
         end
      end

      wait_idle();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("conv2d_3x3_zero_pad regression: pass");
      end else begin
         $display("conv2d_3x3_zero_pad regression: fail");
      end
      $finish;
   end

endmodule
